>>> hdl/cpr_pkg.sv
// Shared constants and types for the clock page replacement block.
package cpr_pkg;

   // Fixed field widths of the request, response and control port
   localparam int CSR_W       = 5;
   localparam int PAGE_W      = 32;
   localparam int FRAME_OUT_W = 4;
   localparam int TOTAL_W     = 32;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_FRAMES = 16;
   localparam int DEF_KEY_BITS   = 32;

   // Frame count after reset
   localparam logic [CSR_W-1:0] CSR_RESET_FRAMES = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_SWEEP,
      ST_DONE
   } cpr_state_type;

endpackage

>>> hdl/clock_page_replacement_top.sv
// Clock (second-chance) page replacement buffer with frame memory and sweep sequencer.
//
//   channel   ports                         direction   handshake
//   request   req_valid/ready, req_page_key in          valid/ready
//   response  rsp_valid/ready, rsp_*        out         valid/ready
//   control   csr_wr_en, csr_wr_data        in          write enable, no wait
//
// A request passes an accept step, one compare per resident frame (up to the
// filled count), a miss step, up to cap+1 hand steps on an eviction, and a
// hand-off of the result to the response register. The frame memory port, one
// entry read per cycle, sets their pace. Reset is synchronous and clears the
// counters, hand, fill count and control register; the memory needs no clearing.
// A new request is taken while a response still waits; completion stalls until
// the response register is free.
module clock_page_replacement_top
   #(
      parameter int MAX_FRAMES = cpr_pkg::DEF_MAX_FRAMES,
      parameter int KEY_BITS   = cpr_pkg::DEF_KEY_BITS
   )
   (
      input  logic                            clock,
      input  logic                            reset,
      input  logic                            req_valid,
      output logic                            req_ready,
      input  logic [cpr_pkg::PAGE_W-1:0]      req_page_key,
      output logic                            rsp_valid,
      input  logic                            rsp_ready,
      output logic                            rsp_was_hit,
      output logic [cpr_pkg::FRAME_OUT_W-1:0] rsp_frame_index,
      output logic                            rsp_filled_empty,
      output logic                            rsp_did_evict,
      output logic [cpr_pkg::PAGE_W-1:0]      rsp_evicted_page,
      output logic [cpr_pkg::TOTAL_W-1:0]     rsp_hit_total,
      output logic [cpr_pkg::TOTAL_W-1:0]     rsp_miss_total,
      output logic [cpr_pkg::TOTAL_W-1:0]     rsp_eviction_total,
      input  logic                            csr_wr_en,
      input  logic [cpr_pkg::CSR_W-1:0]       csr_wr_data
   );

   import cpr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);

   // Frame memory: reference bit on top of the key
   logic [KEY_BITS:0] frame_mem [MAX_FRAMES];

   cpr_state_type state_ff, state_in;

   logic [CSR_W-1:0]   csr_frames_ff;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   filled_ff, filled_in;
   logic [IDX_W-1:0]   hand_ff, hand_in;
   logic [TOTAL_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [TOTAL_W-1:0] evict_cnt_ff, evict_cnt_in;

   logic               res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]   res_frame_ff, res_frame_in;
   logic               res_fill_ff, res_fill_in;
   logic               res_evict_ff, res_evict_in;
   logic [KEY_BITS-1:0] res_old_ff, res_old_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff;
   logic               rsp_fill_ff;
   logic               rsp_evict_ff;
   logic [PAGE_W-1:0]  rsp_old_ff;
   logic [TOTAL_W-1:0] rsp_hit_tot_ff;
   logic [TOTAL_W-1:0] rsp_miss_tot_ff;
   logic [TOTAL_W-1:0] rsp_evict_tot_ff;

   logic [KEY_BITS:0]  rd_data_ff;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [KEY_BITS:0]  mem_wr_data;

   logic [CNT_W-1:0]   cap_now;
   logic [CNT_W-1:0]   live_now;
   logic               req_fire;
   logic               rsp_load;
   logic               rd_ref;
   logic [KEY_BITS-1:0] rd_key;
   logic [IDX_W-1:0]   hand_start;
   logic [IDX_W-1:0]   hand_next;
   logic               scan_match;
   logic               scan_last;

   // Active frame count: zero acts as one, clamp to the memory depth
   always_comb begin
      if (csr_frames_ff == '0) begin
         cap_now = CNT_W'(1);
      end else if (int'(csr_frames_ff) > MAX_FRAMES) begin
         cap_now = CNT_W'(MAX_FRAMES);
      end else begin
         cap_now = CNT_W'(csr_frames_ff);
      end
      live_now = (filled_ff < cap_now) ? filled_ff : cap_now;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rd_ref     = rd_data_ff[KEY_BITS];
   assign rd_key     = rd_data_ff[KEY_BITS-1:0];
   assign scan_match = (rd_key == key_ff);
   assign scan_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == live_ff);
   assign hand_start = (CNT_W'(hand_ff) >= cap_ff) ? '0 : hand_ff;
   assign hand_next  = ((CNT_W'(hand_ff) + CNT_W'(1)) == cap_ff) ? '0
                       : IDX_W'(CNT_W'(hand_ff) + CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (live_now == '0) ? ST_MISS : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_match) begin
               state_in = ST_DONE;
            end else if (scan_last) begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            state_in = (filled_ff < cap_ff) ? ST_DONE : ST_SWEEP;
         end
         ST_SWEEP: begin
            if (!rd_ref) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and next values
   always_comb begin
      key_in       = key_ff;
      cap_in       = cap_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      filled_in    = filled_ff;
      hand_in      = hand_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      res_hit_in   = res_hit_ff;
      res_frame_in = res_frame_ff;
      res_fill_in  = res_fill_ff;
      res_evict_in = res_evict_ff;
      res_old_in   = res_old_ff;
      mem_rd_addr  = idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = {1'b1, key_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            key_in       = KEY_BITS'(req_page_key);
            cap_in       = cap_now;
            live_in      = live_now;
            idx_in       = '0;
            mem_rd_addr  = '0;
            res_hit_in   = 1'b0;
            res_fill_in  = 1'b0;
            res_evict_in = 1'b0;
            res_old_in   = '0;
         end
         ST_SCAN: begin
            if (scan_match) begin
               mem_wr_en    = 1'b1;
               res_hit_in   = 1'b1;
               res_frame_in = idx_ff;
               hit_cnt_in   = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + 1'b1;
            end else begin
               // prefetch the next frame while this one is compared
               idx_in      = IDX_W'(CNT_W'(idx_ff) + CNT_W'(1));
               mem_rd_addr = IDX_W'(CNT_W'(idx_ff) + CNT_W'(1));
            end
         end
         ST_MISS: begin
            miss_cnt_in = (miss_cnt_ff == '1) ? miss_cnt_ff : miss_cnt_ff + 1'b1;
            if (filled_ff < cap_ff) begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = IDX_W'(filled_ff);
               filled_in    = filled_ff + 1'b1;
               res_fill_in  = 1'b1;
               res_frame_in = IDX_W'(filled_ff);
            end else begin
               hand_in     = hand_start;
               mem_rd_addr = hand_start;
            end
         end
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = hand_ff;
            hand_in     = hand_next;
            if (rd_ref) begin
               // second chance: clear the bit and advance
               mem_wr_data = {1'b0, rd_key};
               mem_rd_addr = hand_next;
            end else begin
               res_evict_in = 1'b1;
               res_frame_in = hand_ff;
               res_old_in   = rd_key;
               evict_cnt_in = (evict_cnt_ff == '1) ? evict_cnt_ff : evict_cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Frame memory, with the write forwarded onto a same-cycle read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         frame_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_wr_en && (mem_wr_addr == mem_rd_addr)) begin
         rd_data_ff <= mem_wr_data;
      end else begin
         rd_data_ff <= frame_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_frames_ff <= CSR_RESET_FRAMES;
         filled_ff     <= '0;
         hand_ff       <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            csr_frames_ff <= csr_wr_data;
         end
         filled_ff     <= filled_in;
         hand_ff       <= hand_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         evict_cnt_ff  <= evict_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      cap_ff       <= cap_in;
      live_ff      <= live_in;
      idx_ff       <= idx_in;
      res_hit_ff   <= res_hit_in;
      res_frame_ff <= res_frame_in;
      res_fill_ff  <= res_fill_in;
      res_evict_ff <= res_evict_in;
      res_old_ff   <= res_old_in;
      if (rsp_load) begin
         rsp_hit_ff       <= res_hit_ff;
         rsp_frame_ff     <= FRAME_OUT_W'(res_frame_ff);
         rsp_fill_ff      <= res_fill_ff;
         rsp_evict_ff     <= res_evict_ff;
         rsp_old_ff       <= PAGE_W'(res_old_ff);
         rsp_hit_tot_ff   <= hit_cnt_ff;
         rsp_miss_tot_ff  <= miss_cnt_ff;
         rsp_evict_tot_ff <= evict_cnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_hit        = rsp_hit_ff;
   assign rsp_frame_index    = rsp_frame_ff;
   assign rsp_filled_empty   = rsp_fill_ff;
   assign rsp_did_evict      = rsp_evict_ff;
   assign rsp_evicted_page   = rsp_old_ff;
   assign rsp_hit_total      = rsp_hit_tot_ff;
   assign rsp_miss_total     = rsp_miss_tot_ff;
   assign rsp_eviction_total = rsp_evict_tot_ff;

endmodule

>>> verif/clock_page_replacement_checker.sv
// Checker for the clock page replacement block: predicts every response and compares it.
`timescale 1ns / 1ps

module clock_page_replacement_checker
   (
      input  logic                            clock,
      input  logic                            reset,
      input  logic                            req_valid,
      input  logic                            req_ready,
      input  logic [cpr_pkg::PAGE_W-1:0]      req_page_key,
      input  logic                            rsp_valid,
      input  logic                            rsp_ready,
      input  logic                            rsp_was_hit,
      input  logic [cpr_pkg::FRAME_OUT_W-1:0] rsp_frame_index,
      input  logic                            rsp_filled_empty,
      input  logic                            rsp_did_evict,
      input  logic [cpr_pkg::PAGE_W-1:0]      rsp_evicted_page,
      input  logic [cpr_pkg::TOTAL_W-1:0]     rsp_hit_total,
      input  logic [cpr_pkg::TOTAL_W-1:0]     rsp_miss_total,
      input  logic [cpr_pkg::TOTAL_W-1:0]     rsp_eviction_total,
      input  logic                            csr_wr_en,
      input  logic [cpr_pkg::CSR_W-1:0]       csr_wr_data,
      output int                              pending_results,
      output int                              mismatch_count
   );

   import cpr_pkg::*;

   localparam int FRAMES     = DEF_MAX_FRAMES;

   typedef struct packed {
      logic                   was_hit;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   filled;
      logic                   evicted;
      logic [PAGE_W-1:0]      evicted_page;
      logic [TOTAL_W-1:0]     hits;
      logic [TOTAL_W-1:0]     misses;
      logic [TOTAL_W-1:0]     evictions;
   } access_outcome_type;

   // Shadow copy of the buffer
   logic [PAGE_W-1:0]  frame_key [FRAMES];
   logic               ref_bit [FRAMES];
   int                 fill_level;
   int                 hand_pos;
   logic [TOTAL_W-1:0] hit_cnt;
   logic [TOTAL_W-1:0] miss_cnt;
   logic [TOTAL_W-1:0] evict_cnt;
   logic [CSR_W-1:0]   frames_cfg;

   access_outcome_type expected_q [$];
   access_outcome_type oldest;
   int                 responses_seen;

   function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic access_outcome_type predict_access(input logic [PAGE_W-1:0] key);
      access_outcome_type res;
      int                 cap;
      int                 live;
      int                 steps;
      bit                 found;
      res   = '0;
      found = 1'b0;
      cap   = int'(frames_cfg);
      if (cap == 0) cap = 1;
      if (cap > FRAMES) cap = FRAMES;
      live = (fill_level < cap) ? fill_level : cap;
      for (int i = 0; i < live; i++) begin
         if (!found && frame_key[i] == key) begin
            found     = 1'b1;
            res.frame = FRAME_OUT_W'(i);
         end
      end
      if (found) begin
         ref_bit[res.frame] = 1'b1;
         hit_cnt            = bump(hit_cnt);
         res.was_hit        = 1'b1;
      end else begin
         miss_cnt = bump(miss_cnt);
         if (fill_level < cap) begin
            res.frame             = FRAME_OUT_W'(fill_level);
            frame_key[fill_level] = key;
            ref_bit[fill_level]   = 1'b1;
            fill_level++;
            res.filled = 1'b1;
         end else begin
            if (hand_pos >= cap) hand_pos = 0;
            // give each referenced frame its second chance
            for (steps = 0; steps <= cap && ref_bit[hand_pos]; steps++) begin
               ref_bit[hand_pos] = 1'b0;
               hand_pos          = (hand_pos + 1) % cap;
            end
            res.frame           = FRAME_OUT_W'(hand_pos);
            res.evicted_page    = frame_key[hand_pos];
            frame_key[hand_pos] = key;
            ref_bit[hand_pos]   = 1'b1;
            hand_pos            = (hand_pos + 1) % cap;
            evict_cnt           = bump(evict_cnt);
            res.evicted         = 1'b1;
         end
      end
      res.hits      = hit_cnt;
      res.misses    = miss_cnt;
      res.evictions = evict_cnt;
      return res;
   endfunction

   task automatic log_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] wanted);
      $display("[%0t] response %0d: %s got %h, want %h",
               $realtime, responses_seen, what, seen, wanted);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            frame_key[i] = '0;
            ref_bit[i]   = 1'b0;
         end
         fill_level     = 0;
         hand_pos       = 0;
         hit_cnt        = '0;
         miss_cnt       = '0;
         evict_cnt      = '0;
         frames_cfg     = CSR_RESET_FRAMES;
         responses_seen = 0;
         mismatch_count = 0;
         expected_q.delete();
         pending_results <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               log_mismatch("response with no request outstanding", 32'd1, 32'd0);
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_was_hit !== oldest.was_hit)
                  log_mismatch("was_hit", 32'(rsp_was_hit), 32'(oldest.was_hit));
               if (rsp_frame_index !== oldest.frame)
                  log_mismatch("frame_index", 32'(rsp_frame_index), 32'(oldest.frame));
               if (rsp_filled_empty !== oldest.filled)
                  log_mismatch("filled_empty", 32'(rsp_filled_empty), 32'(oldest.filled));
               if (rsp_did_evict !== oldest.evicted)
                  log_mismatch("did_evict", 32'(rsp_did_evict), 32'(oldest.evicted));
               if (rsp_evicted_page !== oldest.evicted_page)
                  log_mismatch("evicted_page", rsp_evicted_page, oldest.evicted_page);
               if (rsp_hit_total !== oldest.hits)
                  log_mismatch("hit_total", rsp_hit_total, oldest.hits);
               if (rsp_miss_total !== oldest.misses)
                  log_mismatch("miss_total", rsp_miss_total, oldest.misses);
               if (rsp_eviction_total !== oldest.evictions)
                  log_mismatch("eviction_total", rsp_eviction_total, oldest.evictions);
            end
            responses_seen++;
         end
         if (req_valid && req_ready)
            expected_q.insert(expected_q.size(), predict_access(req_page_key));
         if (csr_wr_en)
            frames_cfg = csr_wr_data;
         pending_results <= expected_q.size();
      end
   end

endmodule

>>> verif/clock_page_replacement_top_tb.sv
// Testbench top for the clock page replacement block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module clock_page_replacement_top_tb;

   import cpr_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 150;
   localparam int HOLD_AT      = 300;
   localparam int POOL_SIZE    = 24;
   localparam int PHASE_ITEMS  = 88;
   localparam int DRAIN_CYCLES = 40;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [PAGE_W-1:0]        req_page_key;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_was_hit;
   logic [FRAME_OUT_W-1:0]   rsp_frame_index;
   logic                     rsp_filled_empty;
   logic                     rsp_did_evict;
   logic [PAGE_W-1:0]        rsp_evicted_page;
   logic [TOTAL_W-1:0]       rsp_hit_total;
   logic [TOTAL_W-1:0]       rsp_miss_total;
   logic [TOTAL_W-1:0]       rsp_eviction_total;
   logic                     csr_wr_en;
   logic [CSR_W-1:0]         csr_wr_data;
   int                       pending_results;
   int                       mismatch_count;

   int                       pages_sent = 0;
   int                       settings_used = 0;
   int                       idle_cycles = 0;
   bit                       eager = 1'b0;
   int                       pool_window = 1;
   logic [PAGE_W-1:0]        key_pool [POOL_SIZE];

   clock_page_replacement_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_page_key       (req_page_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_was_hit        (rsp_was_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_filled_empty   (rsp_filled_empty),
      .rsp_did_evict      (rsp_did_evict),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   clock_page_replacement_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_page_key       (req_page_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_was_hit        (rsp_was_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_filled_empty   (rsp_filled_empty),
      .rsp_did_evict      (rsp_did_evict),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .pending_results    (pending_results),
      .mismatch_count     (mismatch_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL clock_page_replacement_top");
            $finish;
         end
      end
   end

   // Response side: random back-pressure, bursts of none, one long hold-off
   initial begin : response_pacer
      int served;
      int stall;
      int burst_left;
      bit no_stall;
      rsp_ready  = 1'b0;
      served     = 0;
      burst_left = 0;
      no_stall   = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(20, 80);
            no_stall   = ($urandom_range(0, 3) == 0);
         end
         burst_left--;
         stall = no_stall ? 0 : $urandom_range(0, 7);
         if (served == HOLD_AT) stall = HOLD_CYCLES;
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         served++;
      end
   end

   task automatic send_page(input logic [PAGE_W-1:0] key);
      int gap;
      gap = eager ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_page_key <= key;
      do @(posedge clock); while (!req_ready);
      pages_sent++;
   endtask

   // Drain the block, then write the frame count while it is idle
   task automatic set_frames(input logic [CSR_W-1:0] count);
      int eff;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
      eff = int'(count);
      if (eff == 0) eff = 1;
      if (eff > DEF_MAX_FRAMES) eff = DEF_MAX_FRAMES;
      pool_window = (eff + 3 < POOL_SIZE) ? eff + 3 : POOL_SIZE;
   endtask

   function automatic logic [PAGE_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return key_pool[$urandom_range(0, pool_window - 1)];
      if (roll == 7) return $urandom();
      return ($urandom_range(0, 1) == 1) ? '1 : '0;
   endfunction

   initial begin : stimulus
      logic [CSR_W-1:0] phase_frames [12];
      phase_frames = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd2, 5'd12,
                       5'd0, 5'd16, 5'd9, 5'd17, 5'd4, 5'd16};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_page_key = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Small buffer: fill, hit, then a sweep that clears every reference bit
      set_frames(5'd3);
      send_page(32'h0000_0000);
      send_page(32'hFFFF_FFFF);
      send_page(32'hA5A5_A5A5);
      send_page(32'h0000_0000);
      send_page(32'h5A5A_5A5A);
      send_page(32'hFFFF_FFFF);
      send_page(32'h1234_5678);

      // Zero acts as one frame; resident keys above it are no longer seen
      set_frames(5'd0);
      send_page(32'hFFFF_FFFF);
      send_page(32'h5A5A_5A5A);
      send_page(32'h5A5A_5A5A);
      send_page(32'h8000_0000);

      // Grow: filling resumes where it stopped
      set_frames(5'd8);
      send_page(32'h0000_0001);
      send_page(32'h1234_5678);
      send_page(32'h7FFF_FFFF);
      send_page(32'h0000_0001);

      // Above the maximum acts as the maximum
      set_frames(5'd31);
      send_page(32'hDEAD_BEEF);
      send_page(32'h0000_0000);
      send_page(32'hFFFF_FFFF);
      send_page(32'hC0FF_EE00);
      send_page(32'h0F0F_0F0F);
      send_page(32'hDEAD_BEEF);

      foreach (phase_frames[p]) begin
         set_frames(phase_frames[p]);
         foreach (key_pool[k]) key_pool[k] = $urandom();
         eager = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) send_page(pick_key());
      end
      eager = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d page requests over %0d frame-count settings, from zero and one",
               pages_sent, settings_used);
      $display("frame up to oversize, with shrink, grow and a %0d-cycle response hold-off.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("PASS clock_page_replacement_top");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL clock_page_replacement_top");
      end
      $finish;
   end

endmodule
